FILE: rtl/bill_colour_vote_core_defines.svh
// Assertion macros for the bill colour vote block.
// Used by files that carry concurrent assertions; depends on nothing else.
`ifndef BILL_COLOUR_VOTE_CORE_DEFINES_SVH
`define BILL_COLOUR_VOTE_CORE_DEFINES_SVH

`ifndef SYNTH

// Checked on every rising clock edge outside reset.
`define BCV_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BCV_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BCV_ASSERT(name, clk, rst_n, prop, msg)
`define BCV_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: rtl/bcv_pkg.sv
// Shared types and constants for the bill colour vote block.
// No dependencies; used by every module of the block.
`default_nettype none

package bcv_pkg;

    localparam int CLASS_COUNT = 8;
    localparam int CLS_W       = $clog2(CLASS_COUNT);
    localparam int TALLY_W     = 6;
    localparam int CNT_W       = 6;
    localparam int LEVEL_W     = 10;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [CNT_W-1:0]   SPD_RESET = 6'd30;

    // Class codes in priority order; the tray slot is never produced.
    localparam logic [CLS_W-1:0] CLS_PINK   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_PURPLE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_BROWN  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_TRAY   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BLUE   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_ORANGE = 3'd5;
    localparam logic [CLS_W-1:0] CLS_YELLOW = 3'd6;
    localparam logic [CLS_W-1:0] CLS_GREEN  = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_in_word;

    typedef struct packed {
        logic [CLS_W-1:0] bin_index;
        logic             nothing_seen;
    } t_out_word;

    // Classification of one sample: hit is low when no box matched.
    typedef struct packed {
        logic             hit;
        logic [CLS_W-1:0] idx;
    } t_cls;

    // One classified sample handed to the tally unit.
    typedef struct packed {
        logic take;
        t_cls cls;
    } t_step;

endpackage

`default_nettype wire

FILE: rtl/bill_colour_vote_core.sv
// Top level of the bill colour vote block: handshakes, class register, result register.
// Depends on bcv_pkg, bcv_classify, bcv_tally and bill_colour_vote_core_defines.svh.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+--------------------------
//   in       | input     | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//   out      | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//   cfg      | input     | i_cfg_we                  | i_cfg_wdata (samples/decision)
//
// One sample word is taken per cycle unless the class register is held. A sample is
// classified into the class register and counted from there; a window-closing
// sample loads the result register as it is counted, and the decision leaves from there.
// Reset clears tallies and counter and sets the window to 30 samples.
// Only a window-closing sample waits on a full result register; others flow on.
`default_nettype none
`include "bill_colour_vote_core_defines.svh"

module bill_colour_vote_core (
    input  var logic                      i_clk,
    input  var logic                      i_rst_n,
    input  var logic                      i_in_valid,
    output var logic                      o_in_ready,
    input  var bcv_pkg::t_in_word         i_in_word,
    output var logic                      o_out_valid,
    input  var logic                      i_out_ready,
    output var bcv_pkg::t_out_word        o_out_word,
    input  var logic                      i_cfg_we,
    input  var logic [bcv_pkg::CNT_W-1:0] i_cfg_wdata
);

    logic [bcv_pkg::CNT_W-1:0] r_spd;
    logic                      r_cls_valid;
    bcv_pkg::t_cls             r_cls;
    bcv_pkg::t_cls             cls_now;
    logic                      r_out_valid;
    bcv_pkg::t_out_word        r_out;
    bcv_pkg::t_step            step;
    bcv_pkg::t_out_word        result;
    logic                      decide;
    logic                      out_free;
    logic                      in_take;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd <= bcv_pkg::SPD_RESET;
        end else if (i_cfg_we) begin
            r_spd <= i_cfg_wdata;
        end
    end

    bcv_classify u_classify (
        .i_word (i_in_word),
        .o_cls  (cls_now)
    );

    // A held sample moves on unless it closes a window while the result is still held.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step.take  = r_cls_valid && (!decide || out_free);
    assign step.cls   = r_cls;
    assign o_in_ready = !r_cls_valid || step.take;
    assign in_take    = i_in_valid && o_in_ready;

    bcv_tally u_tally (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_window_cfg (r_spd),
        .o_decide     (decide),
        .o_result     (result)
    );

    // Class register between the classifier and the tally unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_valid <= 1'b0;
        end else if (in_take) begin
            r_cls_valid <= 1'b1;
        end else if (step.take) begin
            r_cls_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cls <= cls_now;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.take && decide) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.take && decide) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `BCV_ASSERT(a_no_tray, i_clk, i_rst_n, r_out_valid |-> (r_out.bin_index != bcv_pkg::CLS_TRAY), "tray slot given as result")
    `BCV_ASSERT(a_black_zero, i_clk, i_rst_n, (r_out_valid && r_out.nothing_seen) |-> (r_out.bin_index == '0), "no-match result with non-zero bin")
    `BCV_ASSERT(a_cls_hold, i_clk, i_rst_n, (r_cls_valid && !step.take) |=> (r_cls_valid && $stable(r_cls)), "held class lost or changed")
    `BCV_ASSERT(a_decide_loads, i_clk, i_rst_n, (step.take && decide) |=> r_out_valid, "window closed without a result")
    `BCV_ASSERT_ALWAYS(a_no_overwrite, i_clk, (i_rst_n && r_out_valid && !i_out_ready) |-> !(step.take && decide), "pending result overwritten")

endmodule

`default_nettype wire

FILE: rtl/bcv_classify.sv
// Colour box classifier: tests one RGB sample against the seven boxes.
// Purely combinational; depends on bcv_pkg.
`default_nettype none

module bcv_classify (
    input  var bcv_pkg::t_in_word i_word,
    output var bcv_pkg::t_cls     o_cls
);

    // Plain absolute bound on a channel.
    function automatic logic in_range(input logic [9:0] v, input logic [9:0] lo,
                                      input logic [9:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Percentage bound: lo*base <= 100*v <= hi*base, all exact integers.
    function automatic logic in_pct(input logic [9:0] v, input logic [9:0] base,
                                    input logic [7:0] lo, input logic [7:0] hi);
        logic [17:0] s;
        logic [17:0] l;
        logic [17:0] h;
        s = 18'(v) * 18'd100;
        l = 18'(base) * 18'(lo);
        h = 18'(base) * 18'(hi);
        return (s >= l) && (s <= h);
    endfunction

    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;

    assign r = i_word.red_level;
    assign g = i_word.green_level;
    assign b = i_word.blue_level;

    // Boxes are tried in priority order; the first match wins.
    always_comb begin
        o_cls.hit = 1'b1;
        o_cls.idx = bcv_pkg::CLS_PINK;
        if (in_range(r, 10'd15, 10'd120) && in_pct(g, r, 8'd20, 8'd50)
                && in_pct(b, r, 8'd20, 8'd60)) begin
            o_cls.idx = bcv_pkg::CLS_PINK;
        end else if (in_range(r, 10'd9, 10'd35) && in_pct(g, r, 8'd50, 8'd100)
                && in_pct(b, r, 8'd65, 8'd140)) begin
            o_cls.idx = bcv_pkg::CLS_PURPLE;
        end else if (in_range(r, 10'd3, 10'd20) && in_pct(g, r, 8'd50, 8'd100)
                && in_range(b, 10'd2, 10'd10)) begin
            o_cls.idx = bcv_pkg::CLS_BROWN;
        end else if (in_pct(r, g, 8'd5, 8'd45) && in_range(g, 10'd12, 10'd100)
                && in_pct(b, g, 8'd60, 8'd150)) begin
            o_cls.idx = bcv_pkg::CLS_BLUE;
        end else if (in_range(r, 10'd7, 10'd120) && in_pct(g, r, 8'd5, 8'd30)
                && in_range(b, 10'd3, 10'd10)) begin
            o_cls.idx = bcv_pkg::CLS_ORANGE;
        end else if (in_range(r, 10'd20, 10'd130) && in_pct(g, r, 8'd60, 8'd100)
                && in_pct(b, r, 8'd25, 8'd65)) begin
            o_cls.idx = bcv_pkg::CLS_YELLOW;
        end else if (in_pct(r, g, 8'd20, 8'd50) && in_range(g, 10'd6, 10'd60)
                && in_range(b, 10'd3, 10'd15)) begin
            o_cls.idx = bcv_pkg::CLS_GREEN;
        end else begin
            o_cls.hit = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bcv_tally.sv
// Vote tallies, sample counter and winner search for the bill colour vote block.
// Depends on bcv_pkg.
`default_nettype none

module bcv_tally (
    input  var logic                       i_clk,
    input  var logic                       i_rst_n,
    input  var bcv_pkg::t_step             i_step,
    input  var logic [bcv_pkg::CNT_W-1:0]  i_window_cfg,
    output var logic                       o_decide,
    output var bcv_pkg::t_out_word         o_result
);

    logic [bcv_pkg::TALLY_W-1:0] r_tally [bcv_pkg::CLASS_COUNT];
    logic [bcv_pkg::TALLY_W-1:0] n_tally [bcv_pkg::CLASS_COUNT];
    logic [bcv_pkg::CNT_W-1:0]   r_sample_count;
    logic [bcv_pkg::CNT_W:0]     count_inc;
    logic [bcv_pkg::CNT_W:0]     window;
    logic [bcv_pkg::TALLY_W-1:0] best;
    logic [bcv_pkg::CLS_W-1:0]   best_idx;

    // A register value of zero stands for the longest window.
    assign window    = (i_window_cfg == '0) ? (bcv_pkg::CNT_W + 1)'(1 << bcv_pkg::CNT_W)
                                            : {1'b0, i_window_cfg};
    assign count_inc = {1'b0, r_sample_count} + 1'b1;
    assign o_decide  = (count_inc >= window);

    // Saturating increment of the matched class only.
    always_comb begin
        for (int i = 0; i < bcv_pkg::CLASS_COUNT; i++) begin
            n_tally[i] = r_tally[i];
            if (i_step.cls.hit && (i_step.cls.idx == bcv_pkg::CLS_W'(i))
                    && (r_tally[i] != bcv_pkg::TALLY_MAX)) begin
                n_tally[i] = r_tally[i] + 1'b1;
            end
        end
    end

    // Highest updated tally; strict compare keeps the lowest index on a tie.
    always_comb begin
        best     = '0;
        best_idx = '0;
        for (int i = 0; i < bcv_pkg::CLASS_COUNT; i++) begin
            if (n_tally[i] > best) begin
                best     = n_tally[i];
                best_idx = bcv_pkg::CLS_W'(i);
            end
        end
        if (best != '0) begin
            o_result.bin_index    = best_idx;
            o_result.nothing_seen = 1'b0;
        end else begin
            o_result.bin_index    = '0;
            o_result.nothing_seen = 1'b1;
        end
    end

    // Tallies and counter advance per taken sample and clear when a window closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            for (int i = 0; i < bcv_pkg::CLASS_COUNT; i++) begin
                r_tally[i] <= '0;
            end
        end else if (i_step.take) begin
            if (o_decide) begin
                r_sample_count <= '0;
                for (int i = 0; i < bcv_pkg::CLASS_COUNT; i++) begin
                    r_tally[i] <= '0;
                end
            end else begin
                r_sample_count <= count_inc[bcv_pkg::CNT_W-1:0];
                for (int i = 0; i < bcv_pkg::CLASS_COUNT; i++) begin
                    r_tally[i] <= n_tally[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: bench/bcv_vote_checker.sv
// Checker for the bill colour vote block: watches the sample, decision and window ports,
// predicts each decision word and compares it with what the block gives.
// Depends on bcv_pkg only.

module bcv_vote_checker
    import bcv_pkg::*;
(
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var logic             i_in_valid,
    input  var logic             i_in_ready,
    input  var t_in_word         i_in_word,
    input  var logic             i_out_valid,
    input  var logic             i_out_ready,
    input  var t_out_word        i_out_word,
    input  var logic             i_cfg_we,
    input  var logic [CNT_W-1:0] i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_decisions
);

    logic [TALLY_W-1:0] class_votes [CLASS_COUNT];
    logic [CNT_W-1:0]   window_reg;
    int unsigned        samples_taken;
    t_out_word          decisions_due [$];

    function automatic bit span_ok(int unsigned v, int unsigned lo, int unsigned hi);
        return v >= lo && v <= hi;
    endfunction

    // The percentage bounds are compared scaled by 100, so the test stays exact.
    function automatic bit share_ok(int unsigned v, int unsigned base,
                                    int unsigned lo, int unsigned hi);
        int unsigned scaled;
        scaled = 100 * v;
        return scaled >= lo * base && scaled <= hi * base;
    endfunction

    // The first colour box that holds the sample wins; the tray slot never does.
    function automatic t_cls sort_colour(t_in_word w);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        t_cls res;
        r = w.red_level;
        g = w.green_level;
        b = w.blue_level;
        res.hit = 1'b1;
        if (span_ok(r, 15, 120) && share_ok(g, r, 20, 50) && share_ok(b, r, 20, 60)) begin
            res.idx = CLS_PINK;
        end else if (span_ok(r, 9, 35) && share_ok(g, r, 50, 100)
                     && share_ok(b, r, 65, 140)) begin
            res.idx = CLS_PURPLE;
        end else if (span_ok(r, 3, 20) && share_ok(g, r, 50, 100) && span_ok(b, 2, 10)) begin
            res.idx = CLS_BROWN;
        end else if (share_ok(r, g, 5, 45) && span_ok(g, 12, 100)
                     && share_ok(b, g, 60, 150)) begin
            res.idx = CLS_BLUE;
        end else if (span_ok(r, 7, 120) && share_ok(g, r, 5, 30) && span_ok(b, 3, 10)) begin
            res.idx = CLS_ORANGE;
        end else if (span_ok(r, 20, 130) && share_ok(g, r, 60, 100)
                     && share_ok(b, r, 25, 65)) begin
            res.idx = CLS_YELLOW;
        end else if (share_ok(r, g, 20, 50) && span_ok(g, 6, 60) && span_ok(b, 3, 15)) begin
            res.idx = CLS_GREEN;
        end else begin
            res.hit = 1'b0;
            res.idx = CLS_PINK;
        end
        return res;
    endfunction

    // All ports are sampled at the rising edge; the window register is taken last.
    always @(posedge i_clk) begin : watch
        t_cls             seen;
        t_out_word        due;
        int unsigned      window;
        int unsigned      best;
        logic [CLS_W-1:0] best_idx;
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) class_votes[i] = '0;
            samples_taken = 0;
            window_reg = SPD_RESET;
            decisions_due.delete();
        end else begin
            // A decision word leaving the block is matched with the oldest one predicted.
            if (i_out_valid && i_out_ready) begin
                o_decisions++;
                if (decisions_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: decision word with none expected: bin_index %0d nothing_seen %0b",
                             $time, i_out_word.bin_index, i_out_word.nothing_seen);
                end else begin
                    due = decisions_due.pop_front();
                    if (i_out_word.bin_index !== due.bin_index) begin
                        o_fail_count++;
                        $display("%0t: bin_index expected %0d, got %0d",
                                 $time, due.bin_index, i_out_word.bin_index);
                    end
                    if (i_out_word.nothing_seen !== due.nothing_seen) begin
                        o_fail_count++;
                        $display("%0t: nothing_seen expected %0b, got %0b",
                                 $time, due.nothing_seen, i_out_word.nothing_seen);
                    end
                end
            end

            // Each accepted sample votes; a full window yields the leading class.
            if (i_in_valid && i_in_ready) begin
                seen = sort_colour(i_in_word);
                if (seen.hit && class_votes[seen.idx] != TALLY_MAX) begin
                    class_votes[seen.idx]++;
                end
                samples_taken++;
                window = (window_reg == '0) ? 64 : window_reg;
                if (samples_taken >= window) begin
                    best = 0;
                    best_idx = CLS_PINK;
                    for (int i = 0; i < CLASS_COUNT; i++) begin
                        if (class_votes[i] > best) begin
                            best = class_votes[i];
                            best_idx = CLS_W'(i);
                        end
                    end
                    due.bin_index = best_idx;
                    due.nothing_seen = (best == 0);
                    decisions_due.push_back(due);
                    for (int i = 0; i < CLASS_COUNT; i++) class_votes[i] = '0;
                    samples_taken = 0;
                end
            end

            if (i_cfg_we) window_reg = i_cfg_wdata;
        end
        o_pending = decisions_due.size();
    end

endmodule

FILE: bench/tb_bill_colour_vote_core.sv
// Testbench top for the bill colour vote block: drives samples, window writes and
// back-pressure, and gives the verdict. Depends on bcv_pkg, bcv_vote_checker and the block.

module tb_bill_colour_vote_core;
    import bcv_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 850;
    localparam int QUIET_FROM    = 750;
    localparam int MIN_DECISIONS = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;

    // Field extremes, samples at the edges of every colour box, a priority overlap and a near miss.
    localparam t_in_word CORNER_WORDS [16] = '{
        '{10'd0,    10'd0,    10'd0},
        '{10'd1023, 10'd1023, 10'd1023},
        '{10'd1023, 10'd0,    10'd0},
        '{10'd0,    10'd1023, 10'd0},
        '{10'd0,    10'd0,    10'd1023},
        '{10'd15,   10'd3,    10'd3},
        '{10'd120,  10'd60,   10'd72},
        '{10'd20,   10'd10,   10'd10},
        '{10'd35,   10'd35,   10'd49},
        '{10'd3,    10'd2,    10'd2},
        '{10'd45,   10'd100,  10'd150},
        '{10'd5,    10'd100,  10'd60},
        '{10'd120,  10'd36,   10'd10},
        '{10'd130,  10'd130,  10'd84},
        '{10'd30,   10'd60,   10'd15},
        '{10'd121,  10'd30,   10'd30}
    };

    // Two-sample windows that end level: yellow against pink, blue against green.
    localparam t_in_word TIE_WORDS [4] = '{
        '{10'd100, 10'd80,  10'd40},
        '{10'd100, 10'd30,  10'd30},
        '{10'd45,  10'd100, 10'd150},
        '{10'd30,  10'd60,  10'd15}
    };

    localparam logic [CLS_W-1:0] COLOUR_CODES [7] = '{
        CLS_PINK, CLS_PURPLE, CLS_BROWN, CLS_BLUE, CLS_ORANGE, CLS_YELLOW, CLS_GREEN
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_word         in_word   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_word;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int decisions;
    int cycles;
    int hold_requests;
    int holds_done;
    bit quiet;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bill_colour_vote_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bcv_vote_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_decisions  (decisions)
    );

    // Watchdog on the whole run.
    always @(posedge clk) cycles++;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb_bill_colour_vote_core failed");
        $finish;
    end

    // Decision side: random stall bursts, a long hold-off on request, none when quiet.
    initial begin
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (quiet || $urandom_range(4) != 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat ($urandom_range(18, 1) - 1) @(negedge clk);
            end
        end
    end

    // A value v with lo% of base <= v <= hi% of base.
    function automatic int unsigned pick_share(int unsigned base, int unsigned lo,
                                               int unsigned hi);
        return $urandom_range((hi * base) / 100, (lo * base + 99) / 100);
    endfunction

    // A sample that lands in the given colour box; the tray code gives dark or raw noise.
    function automatic t_in_word make_sample(logic [CLS_W-1:0] kind);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        t_in_word    w;
        case (kind)
            CLS_PINK: begin
                r = $urandom_range(120, 15);
                g = pick_share(r, 20, 50);
                b = pick_share(r, 20, 60);
            end
            CLS_PURPLE: begin
                r = $urandom_range(35, 9);
                g = pick_share(r, 50, 100);
                b = pick_share(r, 65, 140);
            end
            CLS_BROWN: begin
                r = $urandom_range(20, 3);
                g = pick_share(r, 50, 100);
                b = $urandom_range(10, 2);
            end
            CLS_BLUE: begin
                g = $urandom_range(100, 12);
                r = pick_share(g, 5, 45);
                b = pick_share(g, 60, 150);
            end
            CLS_ORANGE: begin
                r = $urandom_range(120, 7);
                g = pick_share(r, 5, 30);
                b = $urandom_range(10, 3);
            end
            CLS_YELLOW: begin
                r = $urandom_range(130, 20);
                g = pick_share(r, 60, 100);
                b = pick_share(r, 25, 65);
            end
            CLS_GREEN: begin
                g = $urandom_range(60, 6);
                r = pick_share(g, 20, 50);
                b = $urandom_range(15, 3);
            end
            default: begin
                if ($urandom_range(1) == 0) begin
                    r = $urandom_range(2);
                    g = $urandom_range(2);
                    b = $urandom_range(2);
                end else begin
                    r = $urandom_range(1023);
                    g = $urandom_range(1023);
                    b = $urandom_range(1023);
                end
            end
        endcase
        w.red_level   = LEVEL_W'(r);
        w.green_level = LEVEL_W'(g);
        w.blue_level  = LEVEL_W'(b);
        return w;
    endfunction

    // Offers one sample word, with an optional gap first; entered and left at a falling edge.
    task automatic send_word(input t_in_word w, input bit gaps);
        int gap;
        if (gaps && $urandom_range(3) == 0) begin
            gap = $urandom_range(18, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering until every decision is out and the last samples have been counted.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CNT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int               phase;
        int               words_sent;
        int               span;
        int               phase_len;
        int               style;
        int               pick;
        logic [CNT_W-1:0] window;
        logic [CLS_W-1:0] lead;
        t_in_word         w;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One-sample windows: every corner sample gives its own decision.
        write_window(CNT_W'(1));
        for (int k = 0; k < 16; k++) send_word(CORNER_WORDS[k], 1'b1);

        // Level tallies go to the lower class index.
        write_window(CNT_W'(2));
        for (int k = 0; k < 4; k++) send_word(TIE_WORDS[k], 1'b1);

        // Window lowered below the samples already taken: the next one closes it.
        write_window(CNT_W'(10));
        for (int k = 0; k < 3; k++) send_word(make_sample(COLOUR_CODES[$urandom_range(6)]), 1'b1);
        write_window(CNT_W'(2));
        send_word(make_sample(CLS_GREEN), 1'b1);

        // Random phases, each with its own window and colour mix.
        phase = 0;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS || decisions < MIN_DECISIONS) begin
            if (phase == 2) begin
                // Long hold on the decision side with one-sample windows fills the block.
                write_window(CNT_W'(1));
                hold_requests++;
                for (int k = 0; k < 24; k++) begin
                    send_word(make_sample(CLS_W'($urandom_range(7))), 1'b0);
                end
                words_sent += 24;
                settle();
            end else begin
                if (phase == 0) begin
                    window = '0;
                end else if (phase == 1) begin
                    window = CNT_W'(63);
                end else begin
                    case ($urandom_range(9))
                        0:       window = '0;
                        1:       window = CNT_W'(1);
                        2:       window = CNT_W'(63);
                        3, 4, 5: window = CNT_W'($urandom_range(8, 2));
                        default: window = CNT_W'($urandom_range(40, 9));
                    endcase
                end
                write_window(window);
                span = (window == '0) ? 64 : window;
                phase_len = span * $urandom_range(3, 1) + $urandom_range(span - 1);
                // A full 64-sample window of one colour drives a tally into saturation.
                style = (phase == 0 || (window == '0 && $urandom_range(1) == 0))
                        ? 0 : $urandom_range(9);
                lead = COLOUR_CODES[$urandom_range(6)];
                for (int k = 0; k < phase_len; k++) begin
                    quiet = (words_sent >= QUIET_FROM);
                    pick = $urandom_range(99);
                    if (style == 0) begin
                        w = make_sample(lead);
                    end else if (style == 1) begin
                        w = make_sample(CLS_TRAY);
                    end else if (pick < 65) begin
                        w = make_sample(lead);
                    end else begin
                        w = make_sample(CLS_W'($urandom_range(7)));
                    end
                    send_word(w, !quiet);
                    words_sent++;
                end
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_bill_colour_vote_core passed");
        end else begin
            $display("tb_bill_colour_vote_core failed");
        end
        $finish;
    end

endmodule
